// ----- hdl/mneg_pkg.sv -----
// ----------------------------------------------------------------------------
// mneg_pkg: shared types and constants of the MIDI note echo generator
// Holds the controller states, the command and status bundles between
// controller and datapath, the slot record and the fixed field constants.
// ----------------------------------------------------------------------------
package mneg_pkg;

	// Request kinds on the input channel
	localparam logic ACT_EVENT = 1'b0;
	localparam logic ACT_TICK  = 1'b1;

	// Event kinds
	localparam logic [1:0] KIND_KEYON = 2'd0;
	localparam logic [1:0] KIND_NOTE  = 2'd1;

	// Register map, index into the register list
	localparam logic [1:0] REG_ECHO_DELAY     = 2'd0;
	localparam logic [1:0] REG_VELOCITY_STEP  = 2'd1;
	localparam logic [1:0] REG_PITCH_STEP     = 2'd2;
	localparam logic [1:0] REG_CHANNEL_FILTER = 2'd3;

	// Register reset values
	localparam logic [15:0] RST_ECHO_DELAY     = 16'd250;
	localparam logic [7:0]  RST_VELOCITY_STEP  = 8'hF6;
	localparam logic [7:0]  RST_PITCH_STEP     = 8'h00;
	localparam logic [4:0]  RST_CHANNEL_FILTER = 5'd0;

	localparam logic [15:0] KEYON_DURATION = 16'd100;
	localparam int          NOTE_LIMIT     = 128;

	// At most this many echoes leave on one tick
	localparam int MAX_ECHOES = 16;
	localparam int ECHO_CNT_W = 4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVENT,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic [31:0] due;
		logic [6:0]  pitch;
		logic [6:0]  velocity;
		logic [3:0]  channel;
		logic [15:0] duration;
	} slot_t;

	typedef struct packed {
		logic [3:0]  channel;
		logic [6:0]  pitch;
		logic [6:0]  velocity;
		logic [15:0] duration;
		logic [31:0] send_time;
	} result_t;

	typedef struct packed {
		logic capture;    // take the input request, clear index and count
		logic advance;    // step to the next slot
		logic ev_write;   // store the event in the current slot
		logic tk_free;    // release the current slot
		logic tk_echo;    // reschedule the current slot, load the pending echo
		logic push_pend;  // move the pending echo to the output register
		logic push_last;  // mark the moved echo as the last of the tick
	} cmd_t;

	typedef struct packed {
		logic ev_ok;       // captured event passes the filters
		logic slot_free;   // current slot is not busy
		logic slot_hit;    // current slot is busy and due
		logic echo_ok;     // shifted note stays in range
		logic idx_last;    // current slot is the last one
		logic cnt_last;    // this echo reaches the per-tick limit
		logic pend_valid;  // an echo waits in the pending register
		logic out_free;    // output register can take a result this cycle
	} sts_t;

endpackage

// ----- hdl/midi_note_echo_generator_unit.sv -----
// ----------------------------------------------------------------------------
// midi_note_echo_generator_unit: MIDI note echo generator
// Stores accepted notes in echo slots and emits shifted echoes on ticks.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_stall) carries either a MIDI event
//   (action 0) or a time tick (action 1). A passing key-on or note takes the
//   lowest free slot, due echo_delay after its stamp. A tick visits each slot
//   at most once, emits one echo per due slot whose shifted note stays in range
//   and frees the others; at most 16 echoes leave per tick, the final one
//   with last set. Results come on out_valid/out_stall.
//   Timing: the slot walk visits one slot per cycle (one memory read port)
//   unless the scan holds for the receiver. An echo leaves one echo
//   later than it is found, or at the end of the tick for the final one.
//   While the output register is stalled and an echo is pending, the scan
//   holds on a new echo; it keeps walking over slots that need no output.
//   Reset clears all busy bits and loads the register defaults; no
//   clearing pass is needed. Write registers over APB only while idle.
// ----------------------------------------------------------------------------
module midi_note_echo_generator_unit #(
	parameter int ECHO_SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [1:0]  event_kind,
	input  logic [3:0]  channel,
	input  logic [6:0]  note_pitch,
	input  logic [6:0]  note_velocity,
	input  logic [15:0] note_duration,
	input  logic [31:0] stamp,
	// echo channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  out_channel,
	output logic [6:0]  out_pitch,
	output logic [6:0]  out_velocity,
	output logic [15:0] out_duration,
	output logic [31:0] send_time,
	output logic        last
);
	import mneg_pkg::*;

	logic [15:0] echo_delay_q;
	logic [7:0]  velocity_step_q;
	logic [7:0]  pitch_step_q;
	logic [4:0]  channel_filter_q;
	logic        cfg_wr;

	cmd_t cmd;
	sts_t sts;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	// register file, word addressed by paddr[3:2]
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_delay_q     <= RST_ECHO_DELAY;
			velocity_step_q  <= RST_VELOCITY_STEP;
			pitch_step_q     <= RST_PITCH_STEP;
			channel_filter_q <= RST_CHANNEL_FILTER;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_ECHO_DELAY:     echo_delay_q     <= pwdata[15:0];
				REG_VELOCITY_STEP:  velocity_step_q  <= pwdata[7:0];
				REG_PITCH_STEP:     pitch_step_q     <= pwdata[7:0];
				REG_CHANNEL_FILTER: channel_filter_q <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_ECHO_DELAY:     prdata = {16'd0, echo_delay_q};
			REG_VELOCITY_STEP:  prdata = {24'd0, velocity_step_q};
			REG_PITCH_STEP:     prdata = {24'd0, pitch_step_q};
			REG_CHANNEL_FILTER: prdata = {27'd0, channel_filter_q};
			default:            prdata = '0;
		endcase
	end

	// sequencer: walk slots, decide store, free, echo or hold
	mneg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_action (action),
		.in_stall  (in_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// slot memory, busy bits, pending echo and output register
	mneg_dp #(
		.ECHO_SLOTS (ECHO_SLOTS)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.event_kind         (event_kind),
		.channel            (channel),
		.note_pitch         (note_pitch),
		.note_velocity      (note_velocity),
		.note_duration      (note_duration),
		.stamp              (stamp),
		.cfg_echo_delay     (echo_delay_q),
		.cfg_velocity_step  (velocity_step_q),
		.cfg_pitch_step     (pitch_step_q),
		.cfg_channel_filter (channel_filter_q),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.out_channel        (out_channel),
		.out_pitch          (out_pitch),
		.out_velocity       (out_velocity),
		.out_duration       (out_duration),
		.send_time          (send_time),
		.last               (last)
	);

endmodule

// ----- hdl/mneg_ctrl.sv -----
// ----------------------------------------------------------------------------
// mneg_ctrl: sequencer of the MIDI note echo generator
// Walks the echo slots one per cycle for events and ticks (a tick holds on
// a stalled output) and steers the pending and output datapath registers.
// ----------------------------------------------------------------------------
module mneg_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_action,
	output logic          in_stall,
	input  mneg_pkg::sts_t sts,
	output mneg_pkg::cmd_t cmd
);
	import mneg_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = (in_action == ACT_TICK) ? ST_SCAN : ST_EVENT;
				end
			end
			ST_EVENT: begin
				if (!sts.ev_ok || sts.slot_free || sts.idx_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (!sts.slot_hit || !sts.echo_ok) begin
					if (sts.idx_last) begin
						state_nxt = ST_FLUSH;
					end
				end else if (!sts.pend_valid || sts.out_free) begin
					if (sts.idx_last || sts.cnt_last) begin
						state_nxt = ST_FLUSH;
					end
				end
			end
			ST_FLUSH: begin
				if (!sts.pend_valid || sts.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
			end
			ST_EVENT: begin
				if (sts.ev_ok) begin
					if (sts.slot_free) begin
						cmd.ev_write = 1'b1;
					end else begin
						cmd.advance = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				if (!sts.slot_hit) begin
					cmd.advance = 1'b1;
				end else if (!sts.echo_ok) begin
					cmd.tk_free = 1'b1;
					cmd.advance = 1'b1;
				end else if (!sts.pend_valid || sts.out_free) begin
					// hold while an older echo cannot leave
					cmd.tk_echo   = 1'b1;
					cmd.advance   = 1'b1;
					cmd.push_pend = sts.pend_valid;
				end
			end
			ST_FLUSH: begin
				if (sts.pend_valid && sts.out_free) begin
					cmd.push_pend = 1'b1;
					cmd.push_last = 1'b1;
				end
			end
			default: begin
				cmd      = '0;
				in_stall = 1'b1;
			end
		endcase
	end

	a_push_safe: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_pend |-> (sts.pend_valid && sts.out_free))
		else $error("pending echo pushed onto an occupied output");

	a_write_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ev_write |-> (sts.ev_ok && sts.slot_free && state_q == ST_EVENT))
		else $error("event stored outside a free slot");

endmodule

// ----- hdl/mneg_dp.sv -----
// ----------------------------------------------------------------------------
// mneg_dp: datapath of the MIDI note echo generator
// Holds the captured request, the slot memory and busy bits, the scan index,
// the echo count, the pending echo and the output register.
// ----------------------------------------------------------------------------
module mneg_dp #(
	parameter int ECHO_SLOTS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  mneg_pkg::cmd_t cmd,
	output mneg_pkg::sts_t sts,
	input  logic [1:0]     event_kind,
	input  logic [3:0]     channel,
	input  logic [6:0]     note_pitch,
	input  logic [6:0]     note_velocity,
	input  logic [15:0]    note_duration,
	input  logic [31:0]    stamp,
	input  logic [15:0]    cfg_echo_delay,
	input  logic [7:0]     cfg_velocity_step,
	input  logic [7:0]     cfg_pitch_step,
	input  logic [4:0]     cfg_channel_filter,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [3:0]     out_channel,
	output logic [6:0]     out_pitch,
	output logic [6:0]     out_velocity,
	output logic [15:0]    out_duration,
	output logic [31:0]    send_time,
	output logic           last
);
	import mneg_pkg::*;

	localparam int            IW       = (ECHO_SLOTS > 1) ? $clog2(ECHO_SLOTS) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(ECHO_SLOTS - 1);

	// captured request
	logic [1:0]  kind_q;
	logic [3:0]  chan_q;
	logic [6:0]  pitch_q;
	logic [6:0]  vel_q;
	logic [15:0] dur_q;
	logic [31:0] stamp_q;

	logic [IW-1:0]         idx_q;
	logic [IW-1:0]         idx_inc;
	logic [IW-1:0]         rd_addr;
	logic [ECHO_CNT_W-1:0] cnt_q;
	logic [ECHO_SLOTS-1:0] busy_q;

	slot_t mem [ECHO_SLOTS];
	slot_t slot_rd_q;
	slot_t mem_wd;
	logic  mem_we;

	logic              pend_valid_q;
	result_t           pend_q;
	logic              out_valid_q;
	result_t           out_q;
	logic              last_q;

	logic signed [8:0] v_sum;
	logic signed [8:0] p_sum;
	logic [31:0]       due_diff;
	logic              chan_match;
	logic [4:0]        chan_code;
	logic [31:0]       delay_ext;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q  <= event_kind;
			chan_q  <= channel;
			pitch_q <= note_pitch;
			vel_q   <= note_velocity;
			dur_q   <= note_duration;
			stamp_q <= stamp;
		end
	end

	assign idx_inc = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;

	// read ahead: the next slot while advancing, the same slot while holding
	always_comb begin
		if (cmd.capture) begin
			rd_addr = '0;
		end else if (cmd.advance || cmd.ev_write) begin
			rd_addr = idx_inc;
		end else begin
			rd_addr = idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			cnt_q  <= '0;
			busy_q <= '0;
		end else begin
			if (cmd.capture) begin
				idx_q <= '0;
				cnt_q <= '0;
			end else begin
				if (cmd.advance) begin
					idx_q <= idx_inc;
				end
				if (cmd.tk_echo) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (cmd.ev_write) begin
				busy_q[idx_q] <= 1'b1;
			end else if (cmd.tk_free) begin
				busy_q[idx_q] <= 1'b0;
			end
		end
	end

	assign delay_ext = {16'd0, cfg_echo_delay};
	assign v_sum     = $signed({2'b00, slot_rd_q.velocity})
		+ $signed({cfg_velocity_step[7], cfg_velocity_step});
	assign p_sum     = $signed({2'b00, slot_rd_q.pitch})
		+ $signed({cfg_pitch_step[7], cfg_pitch_step});
	assign due_diff  = stamp_q - slot_rd_q.due;

	always_comb begin
		mem_we = cmd.ev_write || cmd.tk_echo;
		if (cmd.ev_write) begin
			mem_wd.due      = stamp_q + delay_ext;
			mem_wd.pitch    = pitch_q;
			mem_wd.velocity = vel_q;
			mem_wd.channel  = chan_q;
			mem_wd.duration = (kind_q == KIND_KEYON) ? KEYON_DURATION : dur_q;
		end else begin
			mem_wd.due      = slot_rd_q.due + delay_ext;
			mem_wd.pitch    = p_sum[6:0];
			mem_wd.velocity = v_sum[6:0];
			mem_wd.channel  = slot_rd_q.channel;
			mem_wd.duration = slot_rd_q.duration;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[idx_q] <= mem_wd;
		end
		slot_rd_q <= mem[rd_addr];
	end

	assign chan_code  = {1'b0, chan_q} + 5'd1;
	assign chan_match = (cfg_channel_filter == 5'd0) || (cfg_channel_filter == chan_code);

	always_comb begin
		sts.ev_ok      = chan_match && (vel_q != 7'd0)
			&& ((kind_q == KIND_KEYON) || (kind_q == KIND_NOTE));
		sts.slot_free  = !busy_q[idx_q];
		sts.slot_hit   = busy_q[idx_q] && !due_diff[31];
		sts.echo_ok    = (v_sum > 9'sd0) && (v_sum < NOTE_LIMIT)
			&& !p_sum[8] && (p_sum < NOTE_LIMIT);
		sts.idx_last   = (idx_q == LAST_IDX);
		sts.cnt_last   = (cnt_q == ECHO_CNT_W'(MAX_ECHOES - 1));
		sts.pend_valid = pend_valid_q;
		sts.out_free   = !out_valid_q || !out_stall;
	end

	// pending echo: waits until the next echo or the end of the tick tells
	// whether it is the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.tk_echo) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.push_pend) begin
				pend_valid_q <= 1'b0;
			end
			if (cmd.push_pend) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tk_echo) begin
			pend_q.channel   <= slot_rd_q.channel;
			pend_q.pitch     <= p_sum[6:0];
			pend_q.velocity  <= v_sum[6:0];
			pend_q.duration  <= slot_rd_q.duration;
			pend_q.send_time <= slot_rd_q.due;
		end
		if (cmd.push_pend) begin
			out_q  <= pend_q;
			last_q <= cmd.push_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_channel  = out_q.channel;
	assign out_pitch    = out_q.pitch;
	assign out_velocity = out_q.velocity;
	assign out_duration = out_q.duration;
	assign send_time    = out_q.send_time;
	assign last         = last_q;

	a_echo_keeps_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.tk_echo && pend_valid_q) |-> cmd.push_pend)
		else $error("pending echo overwritten");

	a_store_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ev_write |=> busy_q[$past(idx_q)])
		else $error("stored slot not marked busy");

endmodule
